>>> sv/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg - shared types and constants for the first-fit segment allocator
// Opcodes, status codes, beat payloads, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int MEM_BYTES  = 1024;
	localparam int PAGE_BYTES = 64;
	localparam int MAX_TEXT   = 8;

	localparam logic [7:0]  FILL_ALLOC  = 8'h2E;
	localparam logic [7:0]  FILL_FREED  = 8'h23;
	localparam logic [15:0] HANDLE_LAST = 16'hFFFF;

	// APB byte address width and register index of init_fill
	localparam int         PADDR_W       = 3;
	localparam logic [0:0] REG_INIT_FILL = 1'b0;

	typedef enum logic [2:0] {
		OP_ALLOC, OP_FREE, OP_READ_NEXT, OP_WRITE_NEXT,
		OP_READ_AT, OP_WRITE_AT, OP_STATS, OP_REINIT
	} op_t;

	typedef enum logic [2:0] {
		ST_OK, ST_BAD_SIZE, ST_NO_ROOM, ST_BAD_HANDLE,
		ST_CURSOR_LIMIT, ST_OUT_OF_BOUNDS
	} status_t;

	typedef struct packed {
		op_t         opcode;
		logic [7:0]  task_id;
		logic [15:0] handle_in;
		logic [10:0] request_bytes;
		logic [9:0]  offset;
		logic [3:0]  length;
		logic [63:0] data_in;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] handle_out;
		logic [9:0]  seg_start;
		logic [10:0] seg_bytes;
		logic [63:0] data_out;
		logic [10:0] free_total;
		logic [10:0] largest_free;
		logic [10:0] smallest_free;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_NEED, S_ASCAN, S_FIND, S_FILL, S_MERGE, S_NX_WAIT,
		S_RD_ISSUE, S_RD_WAIT, S_WR, S_STATS, S_DONE
	} fsm_t;

	typedef enum logic [2:0] {
		FK_NONE, FK_REINIT, FK_ALLOC, FK_FREED, FK_MERGE
	} fill_t;

	typedef struct packed {
		logic    idle;
		logic    load_item;
		logic    need_step;
		logic    idx_clr;
		logic    idx_inc;
		logic    alloc_take;
		logic    free_mark;
		logic    merge_take;
		logic    prev_load;
		logic    cursor_inc;
		logic    tbl_reset;
		logic    stats_acc;
		fill_t   fill_start;
		logic    fill_step;
		logic    rd_next;
		logic    wr_next;
		logic    cap_next;
		logic    rd_at;
		logic    cap_at;
		logic    wr_at;
		logic    set_status;
		status_t status_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		op_t  in_op;
		op_t  op;
		logic need_short;
		logic need_bad;
		logic at_end;
		logic fit;
		logic match;
		logic cur_limit;
		logic off_bad;
		logic bytes_done;
		logic merge_pair;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

>>> sv/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl - sequencing state machine
// Steps each operation through table scans, store fills and byte moves.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  ffsa_pkg::sts_t  sts,
	output ffsa_pkg::cmd_t  cmd
);

	ffsa_pkg::fsm_t state_q, state_d;
	ffsa_pkg::fsm_t ret_q, ret_d;

	// reset starts with the clearing pass over the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::S_FILL;
			ret_q   <= ffsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		ret_d           = ret_q;
		cmd             = '0;
		cmd.fill_start  = ffsa_pkg::FK_NONE;
		cmd.status_code = ffsa_pkg::ST_OK;
		unique case (state_q)
			ffsa_pkg::S_IDLE: begin
				cmd.idle = 1'b1;
				if (req_valid) begin
					cmd.load_item = 1'b1;
					case (sts.in_op)
						ffsa_pkg::OP_ALLOC: state_d = ffsa_pkg::S_NEED;
						ffsa_pkg::OP_STATS: state_d = ffsa_pkg::S_STATS;
						ffsa_pkg::OP_REINIT: begin
							cmd.tbl_reset  = 1'b1;
							cmd.fill_start = ffsa_pkg::FK_REINIT;
							ret_d          = ffsa_pkg::S_DONE;
							state_d        = ffsa_pkg::S_FILL;
						end
						default: state_d = ffsa_pkg::S_FIND;
					endcase
				end
			end
			ffsa_pkg::S_NEED: begin
				if (sts.need_short) begin
					cmd.need_step = 1'b1;
				end else if (sts.need_bad) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ffsa_pkg::ST_BAD_SIZE;
					state_d         = ffsa_pkg::S_DONE;
				end else begin
					state_d = ffsa_pkg::S_ASCAN;
				end
			end
			ffsa_pkg::S_ASCAN: begin
				if (sts.at_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ffsa_pkg::ST_NO_ROOM;
					state_d         = ffsa_pkg::S_DONE;
				end else if (sts.fit) begin
					cmd.alloc_take = 1'b1;
					cmd.fill_start = ffsa_pkg::FK_ALLOC;
					ret_d          = ffsa_pkg::S_DONE;
					state_d        = ffsa_pkg::S_FILL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ffsa_pkg::S_FIND: begin
				if (sts.at_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ffsa_pkg::ST_BAD_HANDLE;
					state_d         = ffsa_pkg::S_DONE;
				end else if (sts.match) begin
					case (sts.op) inside
						ffsa_pkg::OP_FREE: begin
							cmd.fill_start = ffsa_pkg::FK_FREED;
							cmd.free_mark  = 1'b1;
							cmd.idx_clr    = 1'b1;
							ret_d          = ffsa_pkg::S_MERGE;
							state_d        = ffsa_pkg::S_FILL;
						end
						ffsa_pkg::OP_READ_NEXT, ffsa_pkg::OP_WRITE_NEXT: begin
							if (sts.cur_limit) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = ffsa_pkg::ST_CURSOR_LIMIT;
								state_d         = ffsa_pkg::S_DONE;
							end else if (sts.op == ffsa_pkg::OP_READ_NEXT) begin
								cmd.rd_next    = 1'b1;
								cmd.cursor_inc = 1'b1;
								state_d        = ffsa_pkg::S_NX_WAIT;
							end else begin
								cmd.wr_next    = 1'b1;
								cmd.cursor_inc = 1'b1;
								state_d        = ffsa_pkg::S_DONE;
							end
						end
						default: begin
							if (sts.off_bad) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = ffsa_pkg::ST_OUT_OF_BOUNDS;
								state_d         = ffsa_pkg::S_DONE;
							end else if (sts.op == ffsa_pkg::OP_READ_AT) begin
								state_d = ffsa_pkg::S_RD_ISSUE;
							end else begin
								state_d = ffsa_pkg::S_WR;
							end
						end
					endcase
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ffsa_pkg::S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ret_q;
				end
			end
			ffsa_pkg::S_MERGE: begin
				if (sts.at_end) begin
					state_d = ffsa_pkg::S_DONE;
				end else if (sts.merge_pair) begin
					cmd.merge_take = 1'b1;
					cmd.fill_start = ffsa_pkg::FK_MERGE;
					ret_d          = ffsa_pkg::S_MERGE;
					state_d        = ffsa_pkg::S_FILL;
				end else begin
					cmd.prev_load = 1'b1;
					cmd.idx_inc   = 1'b1;
				end
			end
			ffsa_pkg::S_NX_WAIT: begin
				cmd.cap_next = 1'b1;
				state_d      = ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_RD_ISSUE: begin
				if (sts.bytes_done) begin
					state_d = ffsa_pkg::S_DONE;
				end else begin
					cmd.rd_at = 1'b1;
					state_d   = ffsa_pkg::S_RD_WAIT;
				end
			end
			ffsa_pkg::S_RD_WAIT: begin
				cmd.cap_at = 1'b1;
				state_d    = ffsa_pkg::S_RD_ISSUE;
			end
			ffsa_pkg::S_WR: begin
				if (sts.bytes_done) begin
					state_d = ffsa_pkg::S_DONE;
				end else begin
					cmd.wr_at = 1'b1;
				end
			end
			ffsa_pkg::S_STATS: begin
				if (sts.at_end) begin
					state_d = ffsa_pkg::S_DONE;
				end else begin
					cmd.stats_acc = 1'b1;
					cmd.idx_inc   = 1'b1;
				end
			end
			ffsa_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ffsa_pkg::S_IDLE;
				end
			end
			default: state_d = ffsa_pkg::S_IDLE;
		endcase
	end

endmodule

>>> sv/ffsa_datapath.sv
// ----------------------------------------------------------------------------
// ffsa_datapath - segment table, byte store and result register
// Executes controller commands on the table, the store and the result beat.
// ----------------------------------------------------------------------------
module ffsa_datapath #(
	parameter int MEM_BYTES  = ffsa_pkg::MEM_BYTES,
	parameter int PAGE_BYTES = ffsa_pkg::PAGE_BYTES,
	parameter int MAX_TEXT   = ffsa_pkg::MAX_TEXT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffsa_pkg::req_t req_item,
	input  logic [7:0]     init_fill,
	input  ffsa_pkg::cmd_t cmd,
	output ffsa_pkg::sts_t sts,
	input  logic           rsp_stall,
	output logic           rsp_valid,
	output ffsa_pkg::rsp_t rsp_item
);

	localparam int AW   = $clog2(MEM_BYTES);
	localparam int EW   = AW + 1;
	localparam int SEGS = (MEM_BYTES + PAGE_BYTES - 1) / PAGE_BYTES + 1;
	localparam int IW   = $clog2(SEGS + 1);
	localparam int NW   = $clog2(2047 + PAGE_BYTES + 1);
	localparam int SWA  = (NW > EW + 1) ? NW : EW + 1;
	localparam int SW   = (SWA > 12) ? SWA : 12;

	typedef struct packed {
		logic          used;
		logic [15:0]   hdl;
		logic [7:0]    tsk;
		logic [EW-1:0] start;
		logic [EW-1:0] size;
		logic [EW-1:0] cur;
	} ent_t;

	localparam ent_t ENT_ZERO  = '0;
	localparam ent_t ENT_FIRST = '{used: 1'b0, hdl: 16'd0, tsk: 8'd0, start: '0,
		size: EW'(MEM_BYTES), cur: '0};

	ent_t           tbl_q [SEGS];
	ent_t           up_w  [SEGS];
	ent_t           dn_w  [SEGS];
	ent_t           e, take_e, rem_e, freed_e;
	logic [IW-1:0]  cnt_q, idx_q;
	logic [15:0]    nh_q;
	logic [NW-1:0]  need_q;
	logic [3:0]     bcnt_q;
	logic [EW-1:0]  faddr_q, fend_q;
	logic [7:0]     fbyte_q;
	logic           prev_free_q;
	logic [EW-1:0]  prev_start_q, prev_size_q;
	logic           out_valid_q, any_q;
	ffsa_pkg::req_t item_q;
	ffsa_pkg::rsp_t out_q;
	ffsa_pkg::status_t status_q;
	logic [15:0]    res_hdl_q;
	logic [EW-1:0]  res_start_q, res_bytes_q;
	logic [63:0]    dacc_q;
	logic [EW-1:0]  tot_q, lg_q, sm_q;

	logic [SW-1:0]  need_x, size_x, start_x, cur_x, offl_x, at_x;
	logic           split;
	logic [EW-1:0]  tsize, msize;
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [7:0]     mem_wdata, mem_rdata;
	logic           out_free;

	for (genvar k = 0; k < SEGS; k++) begin : g_nb
		if (k == 0) begin : g_lo
			assign up_w[k] = ENT_ZERO;
		end else begin : g_up
			assign up_w[k] = tbl_q[k-1];
		end
		if (k == SEGS - 1) begin : g_hi
			assign dn_w[k] = ENT_ZERO;
		end else begin : g_dn
			assign dn_w[k] = tbl_q[k+1];
		end
	end

	always_comb begin
		e = ENT_ZERO;
		for (int k = 0; k < SEGS; k++) begin
			if (idx_q == IW'(k)) begin
				e = tbl_q[k];
			end
		end
	end

	assign need_x  = SW'(need_q);
	assign size_x  = SW'(e.size);
	assign start_x = SW'(e.start);
	assign cur_x   = SW'(e.cur);
	assign offl_x  = SW'(item_q.offset) + SW'(item_q.length);
	assign at_x    = start_x + SW'(item_q.offset) + SW'(bcnt_q);
	assign split   = (size_x > need_x) && (cnt_q < IW'(SEGS));
	assign tsize   = split ? EW'(need_q) : e.size;
	assign msize   = EW'(SW'(prev_size_q) + size_x);

	always_comb begin
		take_e       = e;
		take_e.used  = 1'b1;
		take_e.hdl   = nh_q;
		take_e.tsk   = item_q.task_id;
		take_e.size  = tsize;
		take_e.cur   = e.start;
		rem_e        = ENT_ZERO;
		rem_e.start  = EW'(start_x + need_x);
		rem_e.size   = EW'(size_x - need_x);
		freed_e      = ENT_ZERO;
		freed_e.start = e.start;
		freed_e.size  = e.size;
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		sts            = '0;
		sts.in_op      = req_item.opcode;
		sts.op         = item_q.opcode;
		sts.need_short = need_x < SW'(item_q.request_bytes);
		sts.need_bad   = (need_q == '0) || (need_x > SW'(MEM_BYTES));
		sts.at_end     = idx_q >= cnt_q;
		sts.fit        = !e.used && (size_x >= need_x);
		sts.match      = e.used && (e.hdl == item_q.handle_in) && (e.tsk == item_q.task_id);
		sts.cur_limit  = (cur_x >= start_x + size_x) || (cur_x >= SW'(MEM_BYTES));
		sts.off_bad    = (item_q.length > 4'(MAX_TEXT)) || (offl_x > size_x);
		sts.bytes_done = bcnt_q >= item_q.length;
		sts.merge_pair = (idx_q != '0) && prev_free_q && !e.used;
		sts.fill_last  = (faddr_q + EW'(1)) == fend_q;
		sts.out_free   = out_free;
	end

	// segment table, entry count and handle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SEGS; k++) begin
				tbl_q[k] <= (k == 0) ? ENT_FIRST : ENT_ZERO;
			end
			cnt_q <= IW'(1);
			nh_q  <= 16'd1;
		end else if (cmd.tbl_reset) begin
			for (int k = 0; k < SEGS; k++) begin
				tbl_q[k] <= (k == 0) ? ENT_FIRST : ENT_ZERO;
			end
			cnt_q <= IW'(1);
			nh_q  <= 16'd1;
		end else if (cmd.alloc_take) begin
			for (int k = 0; k < SEGS; k++) begin
				if (split && IW'(k) > idx_q + IW'(1)) begin
					tbl_q[k] <= up_w[k];
				end else if (split && IW'(k) == idx_q + IW'(1)) begin
					tbl_q[k] <= rem_e;
				end else if (IW'(k) == idx_q) begin
					tbl_q[k] <= take_e;
				end
			end
			if (split) begin
				cnt_q <= cnt_q + IW'(1);
			end
			nh_q <= (nh_q == ffsa_pkg::HANDLE_LAST) ? 16'd1 : nh_q + 16'd1;
		end else if (cmd.free_mark) begin
			for (int k = 0; k < SEGS; k++) begin
				if (IW'(k) == idx_q) begin
					tbl_q[k] <= freed_e;
				end
			end
		end else if (cmd.merge_take) begin
			for (int k = 0; k < SEGS; k++) begin
				if (IW'(k) == idx_q - IW'(1)) begin
					tbl_q[k].size <= msize;
				end else if (IW'(k) >= idx_q) begin
					tbl_q[k] <= dn_w[k];
				end
			end
			cnt_q <= cnt_q - IW'(1);
		end else if (cmd.cursor_inc) begin
			for (int k = 0; k < SEGS; k++) begin
				if (IW'(k) == idx_q) begin
					tbl_q[k].cur <= e.cur + EW'(1);
				end
			end
		end
	end

	// scan index, size rounding, byte counter, fill engine, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			need_q      <= '0;
			bcnt_q      <= '0;
			faddr_q     <= '0;
			fend_q      <= EW'(MEM_BYTES);
			fbyte_q     <= 8'd0;
			prev_free_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.load_item) begin
				need_q <= '0;
				bcnt_q <= '0;
			end else begin
				if (cmd.need_step) begin
					need_q <= need_q + NW'(PAGE_BYTES);
				end
				if (cmd.cap_at || cmd.wr_at) begin
					bcnt_q <= bcnt_q + 4'd1;
				end
			end
			if (cmd.idx_clr) begin
				prev_free_q <= 1'b0;
			end else if (cmd.prev_load) begin
				prev_free_q <= !e.used;
			end
			case (cmd.fill_start)
				ffsa_pkg::FK_REINIT: begin
					faddr_q <= '0;
					fend_q  <= EW'(MEM_BYTES);
					fbyte_q <= init_fill;
				end
				ffsa_pkg::FK_ALLOC: begin
					faddr_q <= e.start;
					fend_q  <= EW'(start_x + SW'(tsize));
					fbyte_q <= ffsa_pkg::FILL_ALLOC;
				end
				ffsa_pkg::FK_FREED: begin
					faddr_q <= e.start;
					fend_q  <= EW'(start_x + size_x);
					fbyte_q <= ffsa_pkg::FILL_FREED;
				end
				ffsa_pkg::FK_MERGE: begin
					faddr_q <= prev_start_q;
					fend_q  <= EW'(SW'(prev_start_q) + SW'(msize));
					fbyte_q <= ffsa_pkg::FILL_ALLOC;
				end
				default: begin
					if (cmd.fill_step) begin
						faddr_q <= faddr_q + EW'(1);
					end
				end
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: captured item, partial results, result beat
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q      <= req_item;
			status_q    <= ffsa_pkg::ST_OK;
			res_hdl_q   <= 16'd0;
			res_start_q <= '0;
			res_bytes_q <= '0;
			dacc_q      <= 64'd0;
			tot_q       <= '0;
			lg_q        <= '0;
			sm_q        <= '0;
			any_q       <= 1'b0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.alloc_take) begin
				res_hdl_q   <= nh_q;
				res_start_q <= e.start;
				res_bytes_q <= tsize;
			end
			if (cmd.cap_next) begin
				dacc_q <= {56'd0, mem_rdata};
			end else if (cmd.cap_at) begin
				dacc_q[8*bcnt_q[2:0] +: 8] <= mem_rdata;
			end
			if (cmd.stats_acc && !e.used) begin
				tot_q <= tot_q + e.size;
				if (e.size > lg_q) begin
					lg_q <= e.size;
				end
				if (!any_q || e.size < sm_q) begin
					sm_q <= e.size;
				end
				any_q <= 1'b1;
			end
		end
		if (cmd.prev_load) begin
			prev_start_q <= e.start;
			prev_size_q  <= e.size;
		end else if (cmd.merge_take) begin
			prev_size_q <= msize;
		end
		if (cmd.out_load) begin
			out_q.status        <= status_q;
			out_q.handle_out    <= res_hdl_q;
			out_q.seg_start     <= 10'(SW'(res_start_q));
			out_q.seg_bytes     <= 11'(SW'(res_bytes_q));
			out_q.data_out      <= dacc_q;
			out_q.free_total    <= 11'(SW'(tot_q));
			out_q.largest_free  <= 11'(SW'(lg_q));
			out_q.smallest_free <= 11'(SW'(sm_q));
		end
	end

	// store port selection
	always_comb begin
		mem_we    = cmd.fill_step || cmd.wr_next || cmd.wr_at;
		mem_waddr = faddr_q[AW-1:0];
		mem_wdata = fbyte_q;
		if (cmd.wr_next) begin
			mem_waddr = e.cur[AW-1:0];
			mem_wdata = item_q.data_in[7:0];
		end else if (cmd.wr_at) begin
			mem_waddr = at_x[AW-1:0];
			mem_wdata = item_q.data_in[8*bcnt_q[2:0] +: 8];
		end
		mem_re    = cmd.rd_next || cmd.rd_at;
		mem_raddr = cmd.rd_next ? e.cur[AW-1:0] : at_x[AW-1:0];
	end

	ffsa_ram #(
		.WIDTH (8),
		.DEPTH (MEM_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

endmodule

>>> sv/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator - first-fit byte-store allocator with coalescing
// Top level: APB register, controller, datapath and checks.
// ----------------------------------------------------------------------------
// Usage
//   Request beats arrive on req_valid/req_stall/req_item, one item at a time;
//   each gives exactly one response beat on rsp_valid/rsp_stall/rsp_item.
//   req_stall is low only while the sequencer is idle.
//   Latency depends on the opcode: a table scan steps through the entries
//   in turn (at most MEM_BYTES/PAGE_BYTES+1 entries), rounding an alloc size
//   steps one page at a time, an alloc or free fill writes the single store
//   write port one byte per cycle, and each merge of a free pair refills the
//   merged range likewise. An offset read issues each byte and then captures
//   it before issuing the next; an offset write stores its bytes one by one.
//   A reinit refills the whole store.
//   After reset a clearing pass writes zero to all MEM_BYTES store bytes;
//   requests are held off until it ends. init_fill is written over APB at
//   byte address 0 and may be written at any time; pready is always high.
//   A finished beat waits in the response register while rsp_stall is high;
//   a new request may be taken meanwhile, and its result is held back until
//   the register frees.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
	parameter int MEM_BYTES  = ffsa_pkg::MEM_BYTES,
	parameter int PAGE_BYTES = ffsa_pkg::PAGE_BYTES,
	parameter int MAX_TEXT   = ffsa_pkg::MAX_TEXT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  ffsa_pkg::req_t               req_item,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output ffsa_pkg::rsp_t               rsp_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ffsa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic           [7:0] init_fill_q;
	ffsa_pkg::cmd_t       cmd;
	ffsa_pkg::sts_t       sts;

	// register file: one byte-wide fill value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_fill_q <= 8'd0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == ffsa_pkg::REG_INIT_FILL) begin
			init_fill_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ffsa_pkg::REG_INIT_FILL) ? {24'd0, init_fill_q} : 32'd0;

	// hold requests off whenever the sequencer is busy
	assign req_stall = !cmd.idle;

	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffsa_datapath #(
		.MEM_BYTES  (MEM_BYTES),
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_TEXT   (MAX_TEXT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.init_fill (init_fill_q),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

	// an accepted beat leaves the idle state at once
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken but sequencer still idle");

	// a result is only loaded into a free response register
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("response register overwritten");

	// fill sweeps own the store port alone
	a_fill_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> !(cmd.wr_next || cmd.wr_at || cmd.rd_next || cmd.rd_at))
		else $error("store access during fill");

endmodule

>>> dv/first_fit_segment_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb - self-checking bench for the allocator
// Drives request beats with random gaps, stalls the response side at random,
// predicts every response from a behavioural copy of the segment table and
// byte store, and compares each response beat field by field in order.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_tb;

	localparam int NUM_SEGS    = ffsa_pkg::MEM_BYTES / ffsa_pkg::PAGE_BYTES + 1;
	localparam int STALL_LIMIT = 20000;   // idle cycles before the watchdog fires
	localparam int SETTLE      = 60;

	typedef struct {
		int base;
		int size;
		int cursor;
		int hnd;
		int owner;
		bit used;
	} seg_rec_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	ffsa_pkg::req_t req_item;
	logic           rsp_valid;
	logic           rsp_stall;
	ffsa_pkg::rsp_t rsp_item;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [ffsa_pkg::PADDR_W-1:0] paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	// predictor state
	logic [7:0] mirror_mem [ffsa_pkg::MEM_BYTES];
	seg_rec_t   seg_tab [NUM_SEGS];
	int         seg_cnt;
	int         next_hnd;
	logic [7:0] fill_byte;

	ffsa_pkg::rsp_t pending_rsp [$];
	int   mismatches;
	int   beats_in;
	int   beats_out;
	int   idle_cycles;
	int   hold_rsp;      // long receiver hold-off, counted down by the receiver
	int   rsp_wait;
	bit   no_gaps;       // stretch with no idling on either side
	int   op_seen [8];
	int   status_seen [8];

	first_fit_segment_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	function automatic void fill_mirror(int base, int size, logic [7:0] v);
		for (int a = base; a < base + size; a++)
			if (a < ffsa_pkg::MEM_BYTES) mirror_mem[a] = v;
	endfunction

	function automatic void restore_one_free();
		for (int i = 0; i < NUM_SEGS; i++)
			seg_tab[i] = '{0, 0, 0, 0, 0, 1'b0};
		seg_tab[0].size = ffsa_pkg::MEM_BYTES;
		seg_cnt = 1;
		next_hnd = 1;
	endfunction

	function automatic int find_owned(int owner, int hnd);
		for (int i = 0; i < seg_cnt; i++)
			if (seg_tab[i].used && seg_tab[i].hnd == hnd && seg_tab[i].owner == owner)
				return i;
		return -1;
	endfunction

	// coalesce neighbouring free segments, refilling each merged range
	function automatic void coalesce();
		int i;
		i = 0;
		while (i + 1 < seg_cnt) begin
			if (!seg_tab[i].used && !seg_tab[i + 1].used) begin
				seg_tab[i].size += seg_tab[i + 1].size;
				for (int j = i + 1; j < seg_cnt - 1; j++)
					seg_tab[j] = seg_tab[j + 1];
				seg_cnt--;
				fill_mirror(seg_tab[i].base, seg_tab[i].size, ffsa_pkg::FILL_ALLOC);
			end else begin
				i++;
			end
		end
	endfunction

	function automatic ffsa_pkg::rsp_t allocator_result(ffsa_pkg::req_t r);
		ffsa_pkg::rsp_t o;
		int   need;
		int   k;
		int   a;
		int   off;
		int   len;
		bit   any;
		o = '0;
		o.status = ffsa_pkg::ST_OK;
		off = int'(r.offset);
		len = int'(r.length);
		case (r.opcode) inside
			ffsa_pkg::OP_ALLOC: begin
				need = ((int'(r.request_bytes) + ffsa_pkg::PAGE_BYTES - 1) /
					ffsa_pkg::PAGE_BYTES) * ffsa_pkg::PAGE_BYTES;
				if (need == 0 || need > ffsa_pkg::MEM_BYTES) begin
					o.status = ffsa_pkg::ST_BAD_SIZE;
				end else begin
					o.status = ffsa_pkg::ST_NO_ROOM;
					for (int i = 0; i < seg_cnt; i++) begin
						if (seg_tab[i].used || seg_tab[i].size < need) continue;
						if (seg_tab[i].size > need && seg_cnt < NUM_SEGS) begin
							for (int j = seg_cnt - 1; j > i; j--)
								seg_tab[j + 1] = seg_tab[j];
							seg_tab[i + 1] = '{seg_tab[i].base + need,
								seg_tab[i].size - need, 0, 0, 0, 1'b0};
							seg_tab[i].size = need;
							seg_cnt++;
						end
						seg_tab[i].used = 1'b1;
						seg_tab[i].hnd = next_hnd;
						next_hnd = (next_hnd >= int'(ffsa_pkg::HANDLE_LAST)) ? 1 : next_hnd + 1;
						seg_tab[i].owner = int'(r.task_id);
						seg_tab[i].cursor = seg_tab[i].base;
						fill_mirror(seg_tab[i].base, seg_tab[i].size, ffsa_pkg::FILL_ALLOC);
						o.status = ffsa_pkg::ST_OK;
						o.handle_out = 16'(seg_tab[i].hnd);
						o.seg_start = 10'(seg_tab[i].base);
						o.seg_bytes = 11'(seg_tab[i].size);
						break;
					end
				end
			end
			ffsa_pkg::OP_FREE, ffsa_pkg::OP_READ_NEXT, ffsa_pkg::OP_WRITE_NEXT,
			ffsa_pkg::OP_READ_AT, ffsa_pkg::OP_WRITE_AT: begin
				k = find_owned(int'(r.task_id), int'(r.handle_in));
				if (k < 0) begin
					o.status = ffsa_pkg::ST_BAD_HANDLE;
				end else if (r.opcode == ffsa_pkg::OP_FREE) begin
					fill_mirror(seg_tab[k].base, seg_tab[k].size, ffsa_pkg::FILL_FREED);
					seg_tab[k] = '{seg_tab[k].base, seg_tab[k].size, 0, 0, 0, 1'b0};
					coalesce();
				end else if (r.opcode == ffsa_pkg::OP_READ_NEXT ||
						r.opcode == ffsa_pkg::OP_WRITE_NEXT) begin
					a = seg_tab[k].cursor;
					if (a >= seg_tab[k].base + seg_tab[k].size || a >= ffsa_pkg::MEM_BYTES) begin
						o.status = ffsa_pkg::ST_CURSOR_LIMIT;
					end else begin
						if (r.opcode == ffsa_pkg::OP_READ_NEXT) o.data_out = 64'(mirror_mem[a]);
						else mirror_mem[a] = r.data_in[7:0];
						seg_tab[k].cursor++;
					end
				end else if (len > ffsa_pkg::MAX_TEXT || off + len > seg_tab[k].size) begin
					o.status = ffsa_pkg::ST_OUT_OF_BOUNDS;
				end else begin
					for (int i = 0; i < len; i++) begin
						a = seg_tab[k].base + off + i;
						if (a >= ffsa_pkg::MEM_BYTES) break;
						if (r.opcode == ffsa_pkg::OP_READ_AT) o.data_out[8*i +: 8] = mirror_mem[a];
						else mirror_mem[a] = r.data_in[8*i +: 8];
					end
				end
			end
			ffsa_pkg::OP_STATS: begin
				any = 1'b0;
				for (int i = 0; i < seg_cnt; i++) begin
					if (seg_tab[i].used) continue;
					o.free_total += 11'(seg_tab[i].size);
					if (seg_tab[i].size > int'(o.largest_free))
						o.largest_free = 11'(seg_tab[i].size);
					if (!any || seg_tab[i].size < int'(o.smallest_free))
						o.smallest_free = 11'(seg_tab[i].size);
					any = 1'b1;
				end
			end
			default: begin
				restore_one_free();
				fill_mirror(0, ffsa_pkg::MEM_BYTES, fill_byte);
			end
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------- sender
	// Offer one beat, hold it until taken, then predict its response.
	task automatic send_beat(input ffsa_pkg::req_t r, output ffsa_pkg::rsp_t predicted);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= r;
		do @(posedge clk); while (req_stall);
		predicted = allocator_result(r);
		pending_rsp.push_back(predicted);
		op_seen[r.opcode]++;
		beats_in++;
	endtask

	task automatic send_op(input ffsa_pkg::op_t op, input int owner, input int hnd,
			input int bytes, input int off, input int len, input logic [63:0] data,
			output ffsa_pkg::rsp_t predicted);
		ffsa_pkg::req_t r;
		r.opcode        = op;
		r.task_id       = 8'(owner);
		r.handle_in     = 16'(hnd);
		r.request_bytes = 11'(bytes);
		r.offset        = 10'(off);
		r.length        = 4'(len);
		r.data_in       = data;
		send_beat(r, predicted);
	endtask

	// Drop valid and wait until every outstanding response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic write_init_fill(input logic [7:0] v);
		drain();
		repeat (SETTLE) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ffsa_pkg::PADDR_W'(4 * ffsa_pkg::REG_INIT_FILL);
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		fill_byte = v;
	endtask

	// ---------------------------------------------------------------- receiver
	task automatic check_beat(input ffsa_pkg::rsp_t exp_b, input ffsa_pkg::rsp_t got);
		status_seen[exp_b.status]++;
		if (got.status !== exp_b.status || got.handle_out !== exp_b.handle_out ||
				got.seg_start !== exp_b.seg_start || got.seg_bytes !== exp_b.seg_bytes ||
				got.data_out !== exp_b.data_out || got.free_total !== exp_b.free_total ||
				got.largest_free !== exp_b.largest_free ||
				got.smallest_free !== exp_b.smallest_free) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch on response %0d", $realtime, beats_out);
				$display("  expected %p", exp_b);
				$display("  actual   %p", got);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				beats_out++;
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected response beat %p", $realtime, rsp_item);
				end else begin
					check_beat(pending_rsp.pop_front(), rsp_item);
				end
				rsp_wait = no_gaps ? 0 : $urandom_range(3);
			end
			if (hold_rsp > 0) begin
				hold_rsp--;
				rsp_stall <= 1'b1;
			end else if (rsp_wait > 0) begin
				rsp_wait--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// Size errors, first fit, every access form, bounds edges and merging.
	task automatic test_directed();
		ffsa_pkg::rsp_t p;
		int   h1;
		int   h2;
		int   h3;
		send_op(ffsa_pkg::OP_ALLOC, 1, 0, 0, 0, 0, '0, p);        // zero bytes
		send_op(ffsa_pkg::OP_ALLOC, 1, 0, 2047, 0, 0, '0, p);     // far too large
		send_op(ffsa_pkg::OP_ALLOC, 1, 0, 1025, 0, 0, '0, p);     // one page over
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_ALLOC, 8'hFF, 0, 1, 0, 0, '0, p);    // rounds up to a page
		h1 = p.handle_out;
		send_op(ffsa_pkg::OP_ALLOC, 2, 0, 1024, 0, 0, '0, p);     // no room left
		send_op(ffsa_pkg::OP_ALLOC, 3, 0, 128, 0, 0, '0, p);
		h2 = p.handle_out;
		send_op(ffsa_pkg::OP_WRITE_NEXT, 8'hFF, h1, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FF5A, p);
		send_op(ffsa_pkg::OP_READ_NEXT, 8'hFF, h1, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_WRITE_AT, 8'hFF, h1, 0, 56, 8, '1, p); // last eight bytes
		send_op(ffsa_pkg::OP_READ_AT, 8'hFF, h1, 0, 56, 8, '0, p);
		send_op(ffsa_pkg::OP_READ_AT, 8'hFF, h1, 0, 0, 8, '0, p);
		send_op(ffsa_pkg::OP_WRITE_AT, 8'hFF, h1, 0, 60, 8, '1, p); // crosses the limit
		send_op(ffsa_pkg::OP_READ_AT, 8'hFF, h1, 0, 0, 9, '0, p);   // overlong length
		send_op(ffsa_pkg::OP_READ_AT, 8'hFF, h1, 0, 1023, 15, '0, p);
		send_op(ffsa_pkg::OP_READ_AT, 8'hFF, h1, 0, 64, 0, '0, p);  // empty access at the end
		send_op(ffsa_pkg::OP_FREE, 3, h1, 0, 0, 0, '0, p);          // wrong owner
		send_op(ffsa_pkg::OP_FREE, 8'hFF, 0, 0, 0, 0, '0, p);       // handle zero
		send_op(ffsa_pkg::OP_READ_NEXT, 3, 16'hFFFF, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_ALLOC, 4, 0, 64, 0, 0, '0, p);
		h3 = p.handle_out;
		send_op(ffsa_pkg::OP_FREE, 8'hFF, h1, 0, 0, 0, '0, p);      // free, no merge
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_FREE, 4, h3, 0, 0, 0, '0, p);          // merges with the tail
		send_op(ffsa_pkg::OP_FREE, 3, h2, 0, 0, 0, '0, p);          // merges on both sides
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
	endtask

	// Walk a cursor across a whole page and one step past its end.
	task automatic test_cursor_limit();
		ffsa_pkg::rsp_t p;
		int   h;
		send_op(ffsa_pkg::OP_ALLOC, 9, 0, 64, 0, 0, '0, p);
		h = p.handle_out;
		for (int i = 0; i <= ffsa_pkg::PAGE_BYTES; i++)
			send_op((i % 2) ? ffsa_pkg::OP_READ_NEXT : ffsa_pkg::OP_WRITE_NEXT, 9, h, 0, 0, 0,
				{$urandom, $urandom}, p);
		send_op(ffsa_pkg::OP_WRITE_NEXT, 9, h, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_READ_AT, 9, h, 0, 0, 8, '0, p);
	endtask

	task automatic test_reinit(input logic [7:0] v);
		ffsa_pkg::rsp_t p;
		int   h;
		write_init_fill(v);
		send_op(ffsa_pkg::OP_REINIT, 0, 0, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_ALLOC, 5, 0, 64, 0, 0, '0, p);
		h = p.handle_out;
		send_op(ffsa_pkg::OP_REINIT, 0, 0, 0, 0, 0, '0, p);       // table back to one segment
		send_op(ffsa_pkg::OP_READ_AT, 5, h, 0, 0, 8, '0, p);      // handle gone
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
	endtask

	function automatic int pick_used();
		int idx [$];
		for (int i = 0; i < seg_cnt; i++)
			if (seg_tab[i].used) idx.push_back(i);
		if (idx.size() == 0) return -1;
		return idx[$urandom_range(idx.size() - 1)];
	endfunction

	// Mostly well-formed traffic on live segments, with noise mixed in.
	task automatic test_random(input int count);
		ffsa_pkg::rsp_t p;
		int    k;
		int    sel;
		int    owner;
		int    hnd;
		int    bytes;
		int    off;
		int    len;
		ffsa_pkg::op_t op;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			k = pick_used();
			if (sel < 30 || k < 0) op = (sel < 2) ? ffsa_pkg::OP_REINIT : ffsa_pkg::OP_ALLOC;
			else if (sel < 45) op = ffsa_pkg::OP_FREE;
			else if (sel < 55) op = ffsa_pkg::OP_READ_NEXT;
			else if (sel < 65) op = ffsa_pkg::OP_WRITE_NEXT;
			else if (sel < 77) op = ffsa_pkg::OP_READ_AT;
			else if (sel < 90) op = ffsa_pkg::OP_WRITE_AT;
			else op = ffsa_pkg::OP_STATS;
			if (op == ffsa_pkg::OP_ALLOC && sel == 2) op = ffsa_pkg::OP_REINIT;
			owner = $urandom_range(255);
			hnd   = $urandom_range(16'hFFFF);
			off   = $urandom_range(1023);
			len   = $urandom_range(15);
			if (k >= 0 && $urandom_range(9) < 8) begin
				owner = seg_tab[k].owner;
				hnd   = seg_tab[k].hnd;
				len   = $urandom_range(9);
				off   = $urandom_range(seg_tab[k].size);
			end
			case ($urandom_range(9))
				0:       bytes = $urandom_range(2047);
				1:       bytes = $urandom_range(1024);
				default: bytes = $urandom_range(1, 256);
			endcase
			send_op(op, owner, hnd, bytes, off, len, {$urandom, $urandom}, p);
		end
	endtask

	// Hold the receiver off while offering beats back to back, so that the
	// response register fills and the input stalls; then pause until empty.
	task automatic test_backpressure();
		ffsa_pkg::rsp_t p;
		no_gaps = 1'b1;
		hold_rsp = 400;
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_ALLOC, 7, 0, 64, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_READ_AT, 7, p.handle_out, 0, 0, 8, '0, p);
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_READ_NEXT, 0, 0, 0, 0, 0, '0, p);
		send_op(ffsa_pkg::OP_STATS, 0, 0, 0, 0, 0, '0, p);
		drain();
		no_gaps = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		hold_rsp = 0;
		rsp_wait = 0;
		no_gaps = 1'b0;
		fill_byte = '0;
		foreach (op_seen[i]) op_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (mirror_mem[i]) mirror_mem[i] = '0;
		restore_one_free();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_cursor_limit();
		test_backpressure();
		test_reinit(8'hFF);
		test_random(180);
		no_gaps = 1'b1;                // a stretch with no idling at all
		test_random(60);
		no_gaps = 1'b0;
		test_reinit(8'h00);
		test_random(150);
		test_reinit(8'($urandom_range(1, 254)));
		test_random(80);
		drain();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d request beats, %0d responses; ops %p, statuses %p",
			beats_in, beats_out, op_seen, status_seen);
		$display("init_fill written with 0x00, 0xff and a random value; %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/ffsa_pkg.sv
sv/ffsa_ram.sv
sv/ffsa_ctrl.sv
sv/ffsa_datapath.sv
sv/first_fit_segment_allocator.sv
dv/first_fit_segment_allocator_tb.sv
